[rtl/utf8cd_pkg.sv]
package utf8cd_pkg;

    // Widths fixed by the byte format
    localparam int CNT_W = 4;   // holds 0..8: leading ones of a byte, result counts
    localparam int CP_W  = 21;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    typedef logic [CNT_W-1:0] cnt_t;

    // Input beat
    typedef struct packed {
        logic [7:0] byte_in;
        logic       final_byte;
    } utf8cd_in_t;

    // Result beat
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            run_last;
        logic            string_end;
    } utf8cd_out_t;

    // Job from the front end: raw_cnt raw bytes are replayed first,
    // then cp follows when has_cp is set
    typedef struct packed {
        cnt_t            raw_cnt;
        logic            has_cp;
        logic [CP_W-1:0] cp;
        logic            fin;
    } utf8cd_job_t;

    // Number of leading one bits of a byte
    function automatic cnt_t lead_ones(input logic [7:0] b);
        cnt_t n;
        logic run;
        n   = '0;
        run = 1'b1;
        for (int i = 7; i >= 0; i--) begin
            if (run && b[i]) begin
                n = n + cnt_t'(1);
            end else begin
                run = 1'b0;
            end
        end
        return n;
    endfunction

    // Decode a sequence of k bytes from the lead and the first three tails
    function automatic logic [CP_W-1:0] decode_seq(input cnt_t k, input logic [7:0] ld,
                                                    input logic [7:0] t0,
                                                    input logic [7:0] t1,
                                                    input logic [7:0] t2);
        logic [CP_W-1:0] cp;
        case (k)
            cnt_t'(1): cp = {13'd0, ld};
            cnt_t'(2): cp = {10'd0, ld[4:0], t0[5:0]};
            cnt_t'(3): cp = {5'd0, ld[3:0], t0[5:0], t1[5:0]};
            cnt_t'(4): cp = {ld[2:0], t0[5:0], t1[5:0], t2[5:0]};
            default:   cp = REPLACEMENT_CP;
        endcase
        return cp;
    endfunction

endpackage

[rtl/utf8cd_front.sv]
module utf8cd_front
    import utf8cd_pkg::*;
#(
    parameter int MAX_SEQ_LEN = 6
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  utf8cd_in_t                  in_data,
    input  logic                        q_full,
    output logic                        push,
    output utf8cd_job_t                 job,
    output logic [MAX_SEQ_LEN-1:0][7:0] raw
);

    localparam int TAIL_DEPTH = MAX_SEQ_LEN - 1;
    localparam int TI_W       = $clog2(TAIL_DEPTH);

    // Sequence state
    logic [7:0]      lead_reg, lead_next;
    logic [7:0]      tail_reg [TAIL_DEPTH];
    logic [TI_W-1:0] tcnt_reg, tcnt_next;
    logic            inseq_reg, inseq_next;

    logic                   accept;
    logic                   is_cont;
    logic                   extend;
    cnt_t                   len;
    cnt_t                   cnt1;
    logic [TAIL_DEPTH-1:0][7:0] tm;
    logic                   produce;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign is_cont  = (in_data.byte_in[7:6] == 2'b10);
    assign extend   = inseq_reg && is_cont;
    assign len      = lead_ones(lead_reg);
    assign cnt1     = cnt_t'(tcnt_reg) + cnt_t'(1);

    // Tails as they stand once the incoming byte is stored
    always_comb begin
        for (int i = 0; i < TAIL_DEPTH; i++) begin
            tm[i] = (tcnt_reg == TI_W'(i)) ? in_data.byte_in : tail_reg[i];
        end
        raw[0] = lead_reg;
        for (int i = 0; i < TAIL_DEPTH; i++) begin
            raw[i+1] = tm[i];
        end
    end

    // Classify the byte and build the job
    always_comb begin
        lead_next   = lead_reg;
        tcnt_next   = tcnt_reg;
        inseq_next  = inseq_reg;
        job.raw_cnt = '0;
        job.has_cp  = 1'b0;
        job.cp      = '0;
        job.fin     = in_data.final_byte;
        if (extend) begin
            if ((len < cnt_t'(MAX_SEQ_LEN)) && ((cnt1 + cnt_t'(1)) == len)) begin
                // complete sequence
                job.has_cp = 1'b1;
                job.cp     = decode_seq(len, lead_reg, tm[0], tm[1], tm[2]);
                tcnt_next  = '0;
                inseq_next = 1'b0;
            end else if ((len >= cnt_t'(MAX_SEQ_LEN)) && (cnt1 == cnt_t'(TAIL_DEPTH))) begin
                // overlong lead: replay everything raw
                job.raw_cnt = cnt_t'(MAX_SEQ_LEN);
                tcnt_next   = '0;
                inseq_next  = 1'b0;
            end else if (in_data.final_byte) begin
                // truncated at string end
                job.has_cp = 1'b1;
                job.cp     = decode_seq(cnt1 + cnt_t'(1), lead_reg, tm[0], tm[1], tm[2]);
                tcnt_next  = '0;
                inseq_next = 1'b0;
            end else begin
                tcnt_next = cnt1[TI_W-1:0];
            end
        end else begin
            // broken sequence replays lead and tails, then the byte starts fresh
            if (inseq_reg) begin
                job.raw_cnt = cnt1;
            end
            tcnt_next  = '0;
            inseq_next = 1'b0;
            if (lead_ones(in_data.byte_in) < cnt_t'(2)) begin
                job.has_cp = 1'b1;
                job.cp     = {13'd0, in_data.byte_in};
            end else begin
                lead_next  = in_data.byte_in;
                inseq_next = !in_data.final_byte;
                if (in_data.final_byte) begin
                    job.has_cp = 1'b1;
                    job.cp     = {13'd0, in_data.byte_in};
                end
            end
        end
    end

    assign produce = (job.raw_cnt != '0) || job.has_cp;
    assign push    = accept && produce;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_reg  <= '0;
            tcnt_reg  <= '0;
            inseq_reg <= 1'b0;
        end else if (accept) begin
            lead_reg  <= lead_next;
            tcnt_reg  <= tcnt_next;
            inseq_reg <= inseq_next;
        end
    end

    // Tail bytes, written on each continuation
    always_ff @(posedge aclk) begin
        if (accept && extend) begin
            tail_reg[tcnt_reg] <= in_data.byte_in;
        end
    end

    a_fin_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && in_data.final_byte |=> !inseq_reg)
        else $error("sequence still pending after final byte");

    a_fin_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && in_data.final_byte |-> push)
        else $error("final byte produced no job");

    a_tcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (inseq_reg |-> tcnt_reg <= TI_W'(MAX_SEQ_LEN - 2)) and
        (!inseq_reg |-> tcnt_reg == '0))
        else $error("tail count out of range");

endmodule

[rtl/utf8cd_queue.sv]
module utf8cd_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/utf8cd_back.sv]
module utf8cd_back
    import utf8cd_pkg::*;
#(
    parameter int MAX_SEQ_LEN = 6
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    input  utf8cd_job_t                 q_job,
    input  logic [MAX_SEQ_LEN-1:0][7:0] q_raw,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output utf8cd_out_t                 m_data
);

    localparam int RI_W = $clog2(MAX_SEQ_LEN);

    cnt_t        idx_reg;
    logic        m_valid_reg;
    utf8cd_out_t m_data_reg;

    cnt_t        total;
    logic        last;
    logic        load;
    utf8cd_out_t beat;

    assign total = q_job.raw_cnt + cnt_t'(q_job.has_cp);
    assign last  = ((idx_reg + cnt_t'(1)) == total);
    assign load  = q_valid && (!m_valid_reg || m_ready);
    assign q_pop = load && last;

    // Next result beat of the head job
    always_comb begin
        if (idx_reg < q_job.raw_cnt) begin
            beat.code_point = {13'd0, q_raw[idx_reg[RI_W-1:0]]};
        end else begin
            beat.code_point = q_job.cp;
        end
        beat.run_last   = last;
        beat.string_end = last && q_job.fin;
    end

    // Walk the job and hold the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                idx_reg     <= last ? '0 : idx_reg + cnt_t'(1);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= beat;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_job_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> total != '0)
        else $error("queued job holds no results");

    a_mid_job_head: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg != '0 |-> q_valid && idx_reg < total)
        else $error("job index without a matching head job");

endmodule

[rtl/utf8_codepoint_decoder_unit.sv]
// UTF-8 to code point decoder. Bytes enter on the s_ channel, one per cycle
// while s_ready is high, with final_byte on the last byte of a string; code
// points leave on the m_ channel, with run_last on the last result of each byte
// and string_end on the last result of the string. A byte that only starts or
// extends a sequence produces nothing; a byte may also produce several results
// (a broken or overlong sequence is replayed as raw bytes, up to MAX_SEQ_LEN of
// them). The front end classifies one byte per cycle unless the queue is full;
// the back end sends one result per cycle unless m_ready holds it, so a byte
// with several results holds the back end, and the two-job queue between them
// sets how long the input keeps flowing before it stalls on such a replay.
module utf8_codepoint_decoder_unit
    import utf8cd_pkg::*;
#(
    parameter int MAX_SEQ_LEN = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  utf8cd_in_t  s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output utf8cd_out_t m_data
);

    localparam int RAW_W = 8 * MAX_SEQ_LEN;
    localparam int JOB_W = $bits(utf8cd_job_t);
    localparam int Q_W   = RAW_W + JOB_W;

    logic                        push, q_full, q_pop, q_valid;
    utf8cd_job_t                 f_job, q_job;
    logic [MAX_SEQ_LEN-1:0][7:0] f_raw, q_raw;
    logic [Q_W-1:0]              q_in, q_out;

    utf8cd_front #(
        .MAX_SEQ_LEN(MAX_SEQ_LEN)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_data  (s_data),
        .q_full   (q_full),
        .push     (push),
        .job      (f_job),
        .raw      (f_raw)
    );

    assign q_in = {f_raw, f_job};

    utf8cd_queue #(
        .WIDTH(Q_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_out)
    );

    assign q_job = q_out[JOB_W-1:0];
    assign q_raw = q_out[Q_W-1:JOB_W];

    utf8cd_back #(
        .MAX_SEQ_LEN(MAX_SEQ_LEN)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_job   (q_job),
        .q_raw   (q_raw),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
